@@ rtl/ptc_pkg.sv @@
// Shared types, constants and prescaler tables for the prescaled timer trio.
// Used by the interfaces' neighbors, the register file, the front, the queue and the back unit.
// No dependencies.
package ptc_pkg;

	localparam int MAX_CYCLES = 15;
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	localparam int CYC_W = 4;
	localparam int RES_W = 11;
	localparam int PRESC_W = 11;
	localparam int CNT8_W = 8;
	localparam int CNT16_W = 16;
	localparam int FLAG_W = 3;
	localparam int IRQ_W = 9;

	// Largest residue: a residue just below the largest prescaler plus a full advance.
	localparam logic [RES_W-1:0] RES_MAX = RES_W'(1023 + MAX_CYCLES);

	// Flag bit positions within a timer's group.
	localparam int FLAG_OVF = 0;
	localparam int FLAG_CMPA = 1;
	localparam int FLAG_CMPB = 2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_T0_CONTROL = 3'd0;
	localparam logic [2:0] REG_T0_COMPARES = 3'd1;
	localparam logic [2:0] REG_T1_CONTROL = 3'd2;
	localparam logic [2:0] REG_T1_COMPARES = 3'd3;
	localparam logic [2:0] REG_T2_CLOCK_SELECT = 3'd4;
	localparam logic [2:0] REG_T2_COMPARES = 3'd5;
	localparam logic [2:0] REG_IRQ_MASKS = 3'd6;

	// Command codes of the input channel.
	localparam logic [1:0] CMD_ADVANCE = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;

	// Timer selector codes.
	localparam logic [1:0] PICK_ZERO = 2'd0;
	localparam logic [1:0] PICK_ONE = 2'd1;
	localparam logic [1:0] PICK_TWO = 2'd2;

	// Waveform mode codes that select clear-on-compare.
	localparam logic [1:0] WGM0_CTC = 2'd2;
	localparam logic [1:0] WGM1_CTC = 2'b01;

	typedef enum logic [1:0] {
		OP_ADV,
		OP_CLR,
		OP_LOAD,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t op;
		logic [CYC_W-1:0] cyc;
		logic [1:0] pick;
		logic [FLAG_W-1:0] clr;
		logic [CNT16_W-1:0] load;
	} job_t;

	typedef struct packed {
		logic [5:0] t0_control;
		logic [15:0] t0_compares;
		logic [4:0] t1_control;
		logic [31:0] t1_compares;
		logic [2:0] t2_clock_select;
		logic [15:0] t2_compares;
		logic [IRQ_W-1:0] irq_masks;
	} cfg_t;

	// Prescaler of timers zero and one; zero means stopped.
	function automatic logic [PRESC_W-1:0] presc_zero_one(input logic [2:0] sel);
		logic [PRESC_W-1:0] p;
		case (sel)
			3'd1: p = PRESC_W'(1);
			3'd2: p = PRESC_W'(8);
			3'd3: p = PRESC_W'(64);
			3'd4: p = PRESC_W'(256);
			3'd5: p = PRESC_W'(1024);
			default: p = '0;
		endcase
		return p;
	endfunction

	// Prescaler of timer two; zero means stopped.
	function automatic logic [PRESC_W-1:0] presc_two(input logic [2:0] sel);
		logic [PRESC_W-1:0] p;
		case (sel)
			3'd1: p = PRESC_W'(1);
			3'd2: p = PRESC_W'(8);
			3'd3: p = PRESC_W'(32);
			3'd4: p = PRESC_W'(64);
			3'd5: p = PRESC_W'(128);
			3'd6: p = PRESC_W'(256);
			3'd7: p = PRESC_W'(1024);
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/ptc_if.sv @@
// Valid/ready channel interfaces of the timer trio: request items in, result items out.
// Stand-alone; payload widths follow the item and result fields.
interface ptc_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [3:0] cycle_count;
	logic [1:0] timer_pick;
	logic [2:0] clear_bits;
	logic [15:0] load_value;

	modport source (output valid, cmd, cycle_count, timer_pick, clear_bits, load_value,
		input ready);
	modport sink (input valid, cmd, cycle_count, timer_pick, clear_bits, load_value,
		output ready);
endinterface

interface ptc_out_if;
	logic valid;
	logic ready;
	logic [7:0] count_zero;
	logic [15:0] count_one;
	logic [7:0] count_two;
	logic [2:0] flags_zero;
	logic [2:0] flags_one;
	logic [2:0] flags_two;
	logic [8:0] irq_raised;

	modport source (output valid, count_zero, count_one, count_two, flags_zero, flags_one,
		flags_two, irq_raised, input ready);
	modport sink (input valid, count_zero, count_one, count_two, flags_zero, flags_one,
		flags_two, irq_raised, output ready);
endinterface

@@ rtl/ptc_regs.sv @@
// Configuration register file of the timer trio behind an APB-style port.
// Depends on ptc_pkg for the register indexes and the cfg_t bundle.
module ptc_regs import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_T0_CONTROL: cfg_q.t0_control <= pwdata[5:0];
				REG_T0_COMPARES: cfg_q.t0_compares <= pwdata[15:0];
				REG_T1_CONTROL: cfg_q.t1_control <= pwdata[4:0];
				REG_T1_COMPARES: cfg_q.t1_compares <= pwdata;
				REG_T2_CLOCK_SELECT: cfg_q.t2_clock_select <= pwdata[2:0];
				REG_T2_COMPARES: cfg_q.t2_compares <= pwdata[15:0];
				REG_IRQ_MASKS: cfg_q.irq_masks <= pwdata[IRQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_T0_CONTROL: prdata = 32'(cfg_q.t0_control);
			REG_T0_COMPARES: prdata = 32'(cfg_q.t0_compares);
			REG_T1_CONTROL: prdata = 32'(cfg_q.t1_control);
			REG_T1_COMPARES: prdata = cfg_q.t1_compares;
			REG_T2_CLOCK_SELECT: prdata = 32'(cfg_q.t2_clock_select);
			REG_T2_COMPARES: prdata = 32'(cfg_q.t2_compares);
			REG_IRQ_MASKS: prdata = 32'(cfg_q.irq_masks);
			default: prdata = '0;
		endcase
	end

endmodule

@@ rtl/ptc_front.sv @@
// Front end of the timer trio: accepts request items and classifies them into jobs.
// Depends on ptc_pkg and ptc_in_if; feeds ptc_queue.
module ptc_front import ptc_pkg::*; (
	ptc_in_if.sink item,
	input logic full,
	output logic push,
	output job_t push_job
);

	logic pick_ok;

	assign item.ready = !full;
	assign push = item.valid && !full;
	assign pick_ok = (item.timer_pick == PICK_ZERO) || (item.timer_pick == PICK_ONE)
		|| (item.timer_pick == PICK_TWO);

	always_comb begin
		push_job.pick = item.timer_pick;
		push_job.clr = item.clear_bits;
		push_job.load = item.load_value;
		if (item.cycle_count > MAX_CYCLES) begin
			push_job.cyc = CYC_W'(MAX_CYCLES);
		end else begin
			push_job.cyc = item.cycle_count;
		end
		// Clears and loads aimed at no timer still report the state, so they become no-ops.
		case (item.cmd)
			CMD_ADVANCE: push_job.op = OP_ADV;
			CMD_CLEAR: push_job.op = pick_ok ? OP_CLR : OP_NOP;
			CMD_LOAD: push_job.op = pick_ok ? OP_LOAD : OP_NOP;
			default: push_job.op = OP_NOP;
		endcase
	end

endmodule

@@ rtl/ptc_queue.sv @@
// Short job queue between the front end and the back unit of the timer trio.
// Depends on ptc_pkg for job_t.
module ptc_queue import ptc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	output logic full,
	input logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t slots_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job = slots_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/ptc_back.sv @@
// Back unit of the timer trio: runs jobs against the timer state, one tick per timer per cycle,
// and holds the result in an output register. Depends on ptc_pkg and ptc_out_if.
module ptc_back import ptc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic head_valid,
	input job_t head_job,
	output logic pop,
	ptc_out_if.source result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TICK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	typedef struct packed {
		logic [CNT16_W-1:0] cnt;
		logic [FLAG_W-1:0] set;
	} tick_t;

	function automatic tick_t do_tick(input logic [CNT16_W-1:0] cnt, input logic wide,
		input logic [CNT16_W-1:0] cmpa, input logic [CNT16_W-1:0] cmpb, input logic ctc);
		tick_t r;
		logic [CNT16_W-1:0] nxt;
		nxt = cnt + CNT16_W'(1);
		if (!wide) begin
			nxt[CNT16_W-1:CNT8_W] = '0;
		end
		r.set = '0;
		if (nxt == '0) begin
			r.set[FLAG_OVF] = 1'b1;
		end
		// Compare B looks at the count after a clear-on-compare.
		if (nxt == cmpa) begin
			r.set[FLAG_CMPA] = 1'b1;
			if (ctc) begin
				nxt = '0;
			end
		end
		if (nxt == cmpb) begin
			r.set[FLAG_CMPB] = 1'b1;
		end
		r.cnt = nxt;
		return r;
	endfunction

	logic [1:0] state_q;
	logic [RES_W-1:0] res0_q, res1_q, res2_q;
	logic [CNT8_W-1:0] cnt0_q;
	logic [CNT16_W-1:0] cnt1_q;
	logic [CNT8_W-1:0] cnt2_q;
	logic [FLAG_W-1:0] flags0_q, flags1_q, flags2_q;
	logic [IRQ_W-1:0] irq_q;
	logic out_valid_q;

	logic [PRESC_W-1:0] presc0, presc1, presc2;
	logic ctc0, ctc1;
	logic due0, due1, due2;
	logic any_due;
	logic out_free;
	tick_t tk0, tk1, tk2;
	logic [IRQ_W-1:0] irq_new;

	assign presc0 = presc_zero_one(cfg.t0_control[2:0]);
	assign presc1 = presc_zero_one(cfg.t1_control[2:0]);
	assign presc2 = presc_two(cfg.t2_clock_select);
	assign ctc0 = !cfg.t0_control[3] && (cfg.t0_control[5:4] == WGM0_CTC);
	assign ctc1 = (cfg.t1_control[4:3] == WGM1_CTC);

	assign due0 = (presc0 != '0) && (res0_q >= presc0);
	assign due1 = (presc1 != '0) && (res1_q >= presc1);
	assign due2 = (presc2 != '0) && (res2_q >= presc2);
	assign any_due = due0 || due1 || due2;

	assign tk0 = do_tick(CNT16_W'(cnt0_q), 1'b0, CNT16_W'(cfg.t0_compares[7:0]),
		CNT16_W'(cfg.t0_compares[15:8]), ctc0);
	assign tk1 = do_tick(cnt1_q, 1'b1, cfg.t1_compares[15:0], cfg.t1_compares[31:16], ctc1);
	assign tk2 = do_tick(CNT16_W'(cnt2_q), 1'b0, CNT16_W'(cfg.t2_compares[7:0]),
		CNT16_W'(cfg.t2_compares[15:8]), 1'b0);

	assign irq_new = {due2 ? tk2.set : 3'b000, due1 ? tk1.set : 3'b000,
		due0 ? tk0.set : 3'b000} & cfg.irq_masks;

	assign pop = (state_q == ST_IDLE) && head_valid;
	assign out_free = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res0_q <= '0;
			res1_q <= '0;
			res2_q <= '0;
			cnt0_q <= '0;
			cnt1_q <= '0;
			cnt2_q <= '0;
			flags0_q <= '0;
			flags1_q <= '0;
			flags2_q <= '0;
			irq_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one being taken in the same cycle.
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						irq_q <= '0;
						state_q <= ST_DONE;
						case (head_job.op)
							OP_ADV: begin
								// Stopped timers keep their residue.
								if (presc0 != '0) begin
									res0_q <= res0_q + RES_W'(head_job.cyc);
								end
								if (presc1 != '0) begin
									res1_q <= res1_q + RES_W'(head_job.cyc);
								end
								if (presc2 != '0) begin
									res2_q <= res2_q + RES_W'(head_job.cyc);
								end
								state_q <= ST_TICK;
							end
							OP_CLR: begin
								case (head_job.pick)
									PICK_ZERO: flags0_q <= flags0_q & ~head_job.clr;
									PICK_ONE: flags1_q <= flags1_q & ~head_job.clr;
									default: flags2_q <= flags2_q & ~head_job.clr;
								endcase
							end
							OP_LOAD: begin
								case (head_job.pick)
									PICK_ZERO: cnt0_q <= head_job.load[CNT8_W-1:0];
									PICK_ONE: cnt1_q <= head_job.load;
									default: cnt2_q <= head_job.load[CNT8_W-1:0];
								endcase
							end
							default: ;
						endcase
					end
				end
				ST_TICK: begin
					if (any_due) begin
						if (due0) begin
							res0_q <= res0_q - presc0;
							cnt0_q <= tk0.cnt[CNT8_W-1:0];
							flags0_q <= flags0_q | tk0.set;
						end
						if (due1) begin
							res1_q <= res1_q - presc1;
							cnt1_q <= tk1.cnt;
							flags1_q <= flags1_q | tk1.set;
						end
						if (due2) begin
							res2_q <= res2_q - presc2;
							cnt2_q <= tk2.cnt[CNT8_W-1:0];
							flags2_q <= flags2_q | tk2.set;
						end
						irq_q <= irq_q | irq_new;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			result.count_zero <= cnt0_q;
			result.count_one <= cnt1_q;
			result.count_two <= cnt2_q;
			result.flags_zero <= flags0_q;
			result.flags_one <= flags1_q;
			result.flags_two <= flags2_q;
			result.irq_raised <= irq_q;
		end
	end

	// Once ticking ends, every running timer has fewer cycles left than one period.
	a_tick_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && ($past(state_q) == ST_TICK) |->
		((presc0 == '0) || (res0_q < presc0)) && ((presc1 == '0) || (res1_q < presc1))
		&& ((presc2 == '0) || (res2_q < presc2)))
		else $error("residue left at or above a prescaler period after ticking");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(res0_q <= RES_MAX) && (res1_q <= RES_MAX) && (res2_q <= RES_MAX))
		else $error("prescaler residue beyond its largest reachable value");

	a_irq_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) |-> ((irq_q & ~cfg.irq_masks) == '0))
		else $error("interrupt raised with its mask bit off");

	a_irq_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) |-> ((irq_q & {flags2_q, flags1_q, flags0_q}) == irq_q))
		else $error("interrupt raised without its flag set");

endmodule

@@ rtl/prescaled_timer_counter_trio.sv @@
// Three prescaled timers (8-bit, 16-bit, 8-bit) with compare A/B match, overflow flags and
// masked interrupt requests. Every request item returns one result with all counts, all flags
// and the interrupts raised by that item. A clear, load or no-op item goes from idle straight
// to the done state; an advance item holds the back unit's tick state while any running timer
// still has a full prescaler period left, with one tick per timer per cycle. A timer completes
// at most 15 periods per advance at prescaler 1, and up to 1038 right after a prescaler is
// lowered while a large residue is held. A two-entry queue lets requests be taken while the
// back unit ticks, and the result register lets the next item start while a result waits.
module prescaled_timer_counter_trio import ptc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	ptc_in_if.sink item,
	ptc_out_if.source result
);

	cfg_t cfg;
	logic push;
	job_t push_job;
	logic full;
	logic pop;
	logic head_valid;
	job_t head_job;

	ptc_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	ptc_front u_front (
		.item(item),
		.full(full),
		.push(push),
		.push_job(push_job)
	);

	ptc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(full),
		.pop(pop),
		.head_valid(head_valid),
		.head_job(head_job)
	);

	ptc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.head_valid(head_valid),
		.head_job(head_job),
		.pop(pop),
		.result(result)
	);

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the prescaled timer trio: directed request table, then random phases.
// Predicts every result from its own timer model and drives the APB port and both channels.
// Depends on ptc_pkg, the channel interfaces and the prescaled_timer_counter_trio RTL.
module tb;
	import ptc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 20000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 70;
	localparam logic [1:0] PICK_NONE = 2'd3;
	localparam int PRESCALE_MAIN [8] = '{0, 1, 8, 64, 256, 1024, 0, 0};
	localparam int PRESCALE_TWO [8] = '{0, 1, 8, 32, 64, 128, 256, 1024};

	typedef struct packed {
		logic [7:0] count_zero;
		logic [15:0] count_one;
		logic [7:0] count_two;
		logic [2:0] flags_zero;
		logic [2:0] flags_one;
		logic [2:0] flags_two;
		logic [8:0] irq_raised;
	} snapshot_t;

	typedef struct packed {
		bit fixed;
		snapshot_t value;
	} pinned_t;

	typedef struct packed {
		bit is_write;
		logic [2:0] reg_idx;
		logic [31:0] reg_value;
		job_t job;
		bit fixed;
		snapshot_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ptc_in_if item_ch ();
	ptc_out_if result_ch ();

	prescaled_timer_counter_trio dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item(item_ch),
		.result(result_ch)
	);

	// Timer model state and the register copy it runs against.
	cfg_t regs;
	int tmr_residue [3];
	logic [15:0] tmr_count [3];
	logic [2:0] tmr_flags [3];

	snapshot_t expected_q [$];
	pinned_t pending_q [$];
	plan_row_t plan_q [$];
	int calm_left [2];
	int errors;
	int results_seen;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_gap(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm_left[side] = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	function automatic logic [2:0] run_timer(input int t, input int cyc, input int presc,
			input logic [15:0] wrap, input logic [15:0] cmpa, input logic [15:0] cmpb,
			input bit ctc, input logic [2:0] mask);
		logic [2:0] raised;
		logic [2:0] hit;
		raised = '0;
		if (presc == 0)
			return '0;
		tmr_residue[t] += cyc;
		while (tmr_residue[t] >= presc) begin
			tmr_residue[t] -= presc;
			hit = '0;
			tmr_count[t] = (tmr_count[t] + 16'd1) & wrap;
			if (tmr_count[t] == 16'd0)
				hit[FLAG_OVF] = 1'b1;
			if (tmr_count[t] == cmpa) begin
				hit[FLAG_CMPA] = 1'b1;
				if (ctc)
					tmr_count[t] = 16'd0;
			end
			// Compare B looks at the count after any clear on compare A.
			if (tmr_count[t] == cmpb)
				hit[FLAG_CMPB] = 1'b1;
			tmr_flags[t] |= hit;
			raised |= hit;
		end
		tmr_residue[t] &= 'h7FF;
		return raised & mask;
	endfunction

	function automatic snapshot_t predict_item(input job_t j);
		int cyc;
		logic [8:0] raised;
		bit ctc_zero;
		bit ctc_one;
		cyc = (j.cyc > MAX_CYCLES) ? MAX_CYCLES : j.cyc;
		raised = '0;
		case (j.op)
			OP_ADV: begin
				ctc_zero = !regs.t0_control[3] && regs.t0_control[5:4] == WGM0_CTC;
				ctc_one = regs.t1_control[4:3] == WGM1_CTC;
				raised[2:0] = run_timer(0, cyc, PRESCALE_MAIN[regs.t0_control[2:0]], 16'h00FF,
					{8'h00, regs.t0_compares[7:0]}, {8'h00, regs.t0_compares[15:8]},
					ctc_zero, regs.irq_masks[2:0]);
				raised[5:3] = run_timer(1, cyc, PRESCALE_MAIN[regs.t1_control[2:0]], 16'hFFFF,
					regs.t1_compares[15:0], regs.t1_compares[31:16], ctc_one,
					regs.irq_masks[5:3]);
				raised[8:6] = run_timer(2, cyc, PRESCALE_TWO[regs.t2_clock_select], 16'h00FF,
					{8'h00, regs.t2_compares[7:0]}, {8'h00, regs.t2_compares[15:8]},
					1'b0, regs.irq_masks[8:6]);
			end
			OP_CLR: begin
				if (j.pick <= PICK_TWO)
					tmr_flags[j.pick] &= ~j.clr;
			end
			OP_LOAD: begin
				if (j.pick <= PICK_TWO)
					tmr_count[j.pick] = (j.pick == PICK_ONE) ? j.load : {8'h00, j.load[7:0]};
			end
			default: ;
		endcase
		return {tmr_count[0][7:0], tmr_count[1], tmr_count[2][7:0],
			tmr_flags[0], tmr_flags[1], tmr_flags[2], raised};
	endfunction

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got)
			note_failure($sformatf("result %0d %s: expected 'h%0h, got 'h%0h",
				results_seen, what, want, got));
	endtask

	task automatic take_result();
		snapshot_t want;
		results_seen++;
		if (expected_q.size() == 0) begin
			note_failure($sformatf("result %0d arrived with no request outstanding",
				results_seen));
			return;
		end
		want = expected_q.pop_front();
		check_field("count_zero", want.count_zero, result_ch.count_zero);
		check_field("count_one", want.count_one, result_ch.count_one);
		check_field("count_two", want.count_two, result_ch.count_two);
		check_field("flags_zero", want.flags_zero, result_ch.flags_zero);
		check_field("flags_one", want.flags_one, result_ch.flags_one);
		check_field("flags_two", want.flags_two, result_ch.flags_two);
		check_field("irq_raised", want.irq_raised, result_ch.irq_raised);
	endtask

	task automatic record_request();
		job_t j;
		pinned_t pin;
		snapshot_t s;
		j.op = op_t'(item_ch.cmd);
		j.cyc = item_ch.cycle_count;
		j.pick = item_ch.timer_pick;
		j.clr = item_ch.clear_bits;
		j.load = item_ch.load_value;
		s = predict_item(j);
		if (pending_q.size() != 0) begin
			pin = pending_q.pop_front();
			if (pin.fixed)
				s = pin.value;
		end
		expected_q.push_back(s);
	endtask

	// Results are checked before the new request is recorded in the same cycle.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				moved = 1'b1;
				take_result();
			end
			if (item_ch.valid && item_ch.ready) begin
				moved = 1'b1;
				record_request();
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: a freshly drawn stall, possibly none, before every result.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(1);
			@(negedge clk);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
		end
	end

	task automatic push_request(input job_t j, input bit fixed, input snapshot_t want);
		int gap;
		gap = draw_gap(0);
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pending_q.push_back({fixed, want});
		item_ch.valid <= 1'b1;
		item_ch.cmd <= j.op;
		item_ch.cycle_count <= j.cyc;
		item_ch.timer_pick <= j.pick;
		item_ch.clear_bits <= j.clr;
		item_ch.load_value <= j.load;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
	endtask

	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write followed by a read back of the same register.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] kept;
		case (idx)
			REG_T0_CONTROL: begin regs.t0_control = value[5:0]; kept = 32'(value[5:0]); end
			REG_T0_COMPARES: begin regs.t0_compares = value[15:0]; kept = 32'(value[15:0]); end
			REG_T1_CONTROL: begin regs.t1_control = value[4:0]; kept = 32'(value[4:0]); end
			REG_T1_COMPARES: begin regs.t1_compares = value; kept = value; end
			REG_T2_CLOCK_SELECT: begin
				regs.t2_clock_select = value[2:0];
				kept = 32'(value[2:0]);
			end
			REG_T2_COMPARES: begin regs.t2_compares = value[15:0]; kept = 32'(value[15:0]); end
			default: begin regs.irq_masks = value[8:0]; kept = 32'(value[8:0]); end
		endcase
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== kept)
			note_failure($sformatf("register %0d reads 'h%0h, expected 'h%0h", idx, prdata,
				kept));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_write(input logic [2:0] idx, input logic [31:0] value);
		plan_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_idx = idx;
		row.reg_value = value;
		plan_q.push_back(row);
	endtask

	task automatic add_request(input op_t op, input logic [3:0] cyc, input logic [1:0] pick,
			input logic [2:0] clr, input logic [15:0] load, input bit fixed,
			input snapshot_t want);
		plan_row_t row;
		row = '0;
		row.job.op = op;
		row.job.cyc = cyc;
		row.job.pick = pick;
		row.job.clr = clr;
		row.job.load = load;
		row.fixed = fixed;
		row.want = want;
		plan_q.push_back(row);
	endtask

	function automatic logic [15:0] draw_compare(input int top);
		return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40))
			: 16'($urandom_range(0, top));
	endfunction

	// Most loads aim just below a wrap or a compare value so that matches happen often.
	function automatic job_t random_job(input bit ramp);
		job_t j;
		int roll;
		logic [15:0] aim;
		roll = $urandom_range(0, 99);
		j.cyc = 4'($urandom_range(0, 15));
		j.clr = 3'($urandom_range(0, 7));
		j.pick = ($urandom_range(0, 15) == 0) ? PICK_NONE : 2'($urandom_range(0, 2));
		if (ramp) begin
			j.op = OP_ADV;
			j.cyc = 4'd15 - 4'($urandom_range(0, 1));
		end else if (roll < 60)
			j.op = OP_ADV;
		else if (roll < 75)
			j.op = OP_CLR;
		else if (roll < 93)
			j.op = OP_LOAD;
		else
			j.op = OP_NOP;
		case (j.pick)
			PICK_ZERO: aim = {8'h00, $urandom_range(0, 1) ? regs.t0_compares[7:0]
				: regs.t0_compares[15:8]};
			PICK_ONE: aim = $urandom_range(0, 1) ? regs.t1_compares[15:0]
				: regs.t1_compares[31:16];
			default: aim = {8'h00, $urandom_range(0, 1) ? regs.t2_compares[7:0]
				: regs.t2_compares[15:8]};
		endcase
		case ($urandom_range(0, 3))
			0: j.load = 16'($urandom);
			1: j.load = 16'hFFFF - 16'($urandom_range(0, 20));
			default: j.load = aim - 16'($urandom_range(0, 20));
		endcase
		return j;
	endfunction

	// Phase 0 slows every timer to its largest prescaler so the residues grow,
	// phase 1 drops to the fastest setting, then both extremes, then random settings.
	task automatic program_phase(input int p);
		logic [31:0] v [7];
		v[0] = $urandom;
		v[1] = {16'($urandom), 8'(draw_compare(255)), 8'(draw_compare(255))};
		v[2] = $urandom;
		v[3] = {draw_compare(65535), draw_compare(65535)};
		v[4] = $urandom;
		v[5] = {16'($urandom), 8'(draw_compare(255)), 8'(draw_compare(255))};
		v[6] = $urandom;
		case (p)
			0: begin
				v[0] = 32'({3'($urandom_range(0, 7)), 3'd5});
				v[2] = 32'({2'($urandom_range(0, 3)), 3'd5});
				v[4] = 32'd7;
			end
			1: begin
				v[0] = 32'h21;
				v[2] = 32'h09;
				v[4] = 32'd1;
				v[6] = 32'h1FF;
			end
			2: foreach (v[i]) v[i] = 32'hFFFF_FFFF;
			3: foreach (v[i]) v[i] = 32'h0;
			default: ;
		endcase
		write_reg(REG_T0_CONTROL, v[0]);
		write_reg(REG_T0_COMPARES, v[1]);
		write_reg(REG_T1_CONTROL, v[2]);
		write_reg(REG_T1_COMPARES, v[3]);
		write_reg(REG_T2_CLOCK_SELECT, v[4]);
		write_reg(REG_T2_COMPARES, v[5]);
		write_reg(REG_IRQ_MASKS, v[6]);
	endtask

	initial begin
		snapshot_t known;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = '0;
		item_ch.cycle_count = '0;
		item_ch.timer_pick = '0;
		item_ch.clear_bits = '0;
		item_ch.load_value = '0;
		result_ch.ready = 1'b0;
		regs = '0;
		errors = 0;
		results_seen = 0;
		quiet_cycles = 0;
		calm_left[0] = 0;
		calm_left[1] = 0;
		for (int t = 0; t < 3; t++) begin
			tmr_residue[t] = 0;
			tmr_count[t] = '0;
			tmr_flags[t] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// All timers are stopped after reset, so these results are plain to see.
		known = '0;
		add_request(OP_ADV, 4'd15, PICK_ZERO, 3'd0, 16'h0000, 1'b1, known);
		known.count_one = 16'hFFFF;
		add_request(OP_LOAD, 4'd0, PICK_ONE, 3'd0, 16'hFFFF, 1'b1, known);
		known.count_zero = 8'hCD;
		add_request(OP_LOAD, 4'd0, PICK_ZERO, 3'd0, 16'hABCD, 1'b1, known);
		known.count_two = 8'h34;
		add_request(OP_LOAD, 4'd0, PICK_TWO, 3'd0, 16'h1234, 1'b1, known);
		add_request(OP_LOAD, 4'd0, PICK_NONE, 3'd0, 16'h5555, 1'b1, known);
		add_request(OP_NOP, 4'd15, PICK_ONE, 3'd7, 16'hFFFF, 1'b1, known);
		add_request(OP_CLR, 4'd0, PICK_NONE, 3'd7, 16'h0000, 1'b1, known);
		add_request(OP_ADV, 4'd0, PICK_ZERO, 3'd0, 16'h0000, 1'b1, known);
		add_write(REG_T0_CONTROL, 32'h01);
		add_write(REG_T0_COMPARES, 32'h02D2);
		add_write(REG_T1_CONTROL, 32'h01);
		add_write(REG_T1_COMPARES, 32'h0010_0005);
		add_write(REG_T2_CLOCK_SELECT, 32'h1);
		add_write(REG_T2_COMPARES, 32'h3A40);
		add_write(REG_IRQ_MASKS, 32'h1FF);
		add_request(OP_ADV, 4'd15, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		add_request(OP_ADV, 4'd0, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		add_request(OP_ADV, 4'd1, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		add_request(OP_CLR, 4'd0, PICK_ZERO, 3'd1, 16'h0000, 1'b0, '0);
		add_request(OP_CLR, 4'd0, PICK_ONE, 3'd7, 16'h0000, 1'b0, '0);
		add_request(OP_CLR, 4'd0, PICK_TWO, 3'd6, 16'h0000, 1'b0, '0);
		add_request(OP_LOAD, 4'd0, PICK_ZERO, 3'd0, 16'h00FE, 1'b0, '0);
		add_request(OP_ADV, 4'd3, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		// Clear on compare A for both timers that support it.
		add_write(REG_T0_CONTROL, 32'h21);
		add_write(REG_T0_COMPARES, 32'h0810);
		add_write(REG_T1_CONTROL, 32'h09);
		add_write(REG_T1_COMPARES, 32'h0002_0004);
		add_write(REG_IRQ_MASKS, 32'h0AA);
		add_request(OP_LOAD, 4'd0, PICK_ONE, 3'd0, 16'h0000, 1'b0, '0);
		add_request(OP_ADV, 4'd15, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		add_request(OP_LOAD, 4'd0, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		add_request(OP_ADV, 4'd15, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		add_request(OP_ADV, 4'd15, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		// Slowest prescalers collect a residue, then timer two drops to a faster one
		// while the other two stop.
		add_write(REG_T0_CONTROL, 32'h05);
		add_write(REG_T1_CONTROL, 32'h05);
		add_write(REG_T2_CLOCK_SELECT, 32'h7);
		add_write(REG_IRQ_MASKS, 32'h155);
		add_request(OP_ADV, 4'd15, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		add_request(OP_ADV, 4'd14, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		add_write(REG_T0_CONTROL, 32'h3F);
		add_write(REG_T1_CONTROL, 32'h1E);
		add_write(REG_T2_CLOCK_SELECT, 32'h2);
		add_request(OP_ADV, 4'd15, PICK_ZERO, 3'd0, 16'h0000, 1'b0, '0);
		add_request(OP_CLR, 4'd0, PICK_ZERO, 3'd7, 16'h0000, 1'b0, '0);

		foreach (plan_q[i]) begin
			if (plan_q[i].is_write) begin
				settle();
				write_reg(plan_q[i].reg_idx, plan_q[i].reg_value);
			end else
				push_request(plan_q[i].job, plan_q[i].fixed, plan_q[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			program_phase(p);
			repeat (PHASE_ITEMS) push_request(random_job(p == 0), 1'b0, '0);
		end

		settle();
		repeat (40) @(posedge clk);
		if (expected_q.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_q.size()));
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
